// ===== src/djs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package djs_pkg;
  localparam int MaxJobs = 64;
  localparam int MaxSlots = 32;
  localparam int JobW = 6;
  localparam int CntW = 7;
  localparam int SlotW = 6;
  localparam int SlotAw = 5;
  localparam int IdW = 7;
  localparam int ProfW = 16;
  localparam int SumW = 22;
  localparam logic [SumW-1:0] SumLimit = 22'h3FFFFF;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SHIFT, ST_RDJOB, ST_SCAN, ST_EMIT, ST_CLEAR
  } state_e;

  typedef struct packed {
    logic [ProfW-1:0] profit;
    logic [SlotW-1:0] deadline;
    logic [IdW-1:0]   id;
  } job_t;
endpackage
`default_nettype wire

// ===== src/deadline_job_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// deadline_job_sequencer: greedy job sequencing with deadlines
// jobs enter on start_i while busy_o is low, one transaction per job, each
// with profit, deadline (saturated to 32) and last_job. up to 64 jobs are
// kept in a job memory in falling-profit order; extras are dropped and
// flagged in jobs_dropped_o.
// each job is stored by insertion: into an empty memory it is written directly,
// otherwise it walks down the sorted memory one entry per step (read,
// compare, shift) past every stored entry of lower profit.
// on a last job, each stored job in order searches the slot memory from its
// deadline downward, one slot per cycle (read then write the first free
// slot). results follow, one slot per cycle, on valid_o for exactly one
// cycle; the receiver cannot stall. finally all 32 slots of the slot memory
// are cleared. busy_o is high while a job walks down the job memory and
// from the last job until the clear ends.
// reset (rst_ni low) clears control state and then clears the slot memory
// before the first job is accepted.
module deadline_job_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [15:0] job_profit_i,
  input  wire logic [7:0]  job_deadline_i,
  input  wire logic        last_job_i,
  output logic             valid_o,
  output logic [5:0]       slot_index_o,
  output logic [6:0]       slot_job_id_o,
  output logic [21:0]      total_profit_o,
  output logic             jobs_dropped_o,
  output logic             last_slot_o
);
  djs_pkg::state_e state_q, state_d;
  logic [djs_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [djs_pkg::SlotW-1:0] maxd_q, maxd_d;
  logic [djs_pkg::SumW-1:0] sum_q, sum_d;
  logic ovf_q, ovf_d, last_q, last_d, rdv_q, rdv_d;
  logic [djs_pkg::CntW-1:0] pos_q, pos_d;
  logic [djs_pkg::SlotW-1:0] slot_q, slot_d;
  djs_pkg::job_t new_q, new_d, cur_q, cur_d;

  logic jwe, swe;
  logic [djs_pkg::JobW-1:0] jwa, jra;
  djs_pkg::job_t jwd, jrd;
  logic [djs_pkg::SlotAw-1:0] swa, sra;
  logic [djs_pkg::IdW-1:0] swd, srd;
  logic [djs_pkg::SlotW-1:0] dsat;
  logic [djs_pkg::SumW:0] sum_add;

  djs_job_mem u_job (.clk_i, .we_i(jwe), .waddr_i(jwa), .wdata_i(jwd),
                     .raddr_i(jra), .rdata_o(jrd));
  djs_slot_mem u_slot (.clk_i, .we_i(swe), .waddr_i(swa), .wdata_i(swd),
                       .raddr_i(sra), .rdata_o(srd));

  assign dsat = (job_deadline_i > 8'd32) ? 6'd32 : job_deadline_i[5:0];
  assign sum_add = {1'b0, sum_q} + {7'd0, cur_q.profit};
  assign busy_o = (state_q != djs_pkg::ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= djs_pkg::ST_CLEAR;
      cnt_q <= '0; maxd_q <= '0; sum_q <= '0; ovf_q <= 1'b0;
      last_q <= 1'b0; rdv_q <= 1'b0; pos_q <= '0; slot_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; maxd_q <= maxd_d; sum_q <= sum_d; ovf_q <= ovf_d;
      last_q <= last_d; rdv_q <= rdv_d; pos_q <= pos_d; slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    cur_q <= cur_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; maxd_d = maxd_q; sum_d = sum_q; ovf_d = ovf_q;
    last_d = last_q; rdv_d = 1'b0; pos_d = pos_q; slot_d = slot_q;
    new_d = new_q; cur_d = cur_q;
    jwe = 1'b0; jwa = pos_q[djs_pkg::JobW-1:0]; jwd = new_q;
    jra = pos_q[djs_pkg::JobW-1:0];
    swe = 1'b0; swa = slot_q[djs_pkg::SlotAw-1:0]; swd = '0;
    sra = slot_q[djs_pkg::SlotAw-1:0];
    valid_o = 1'b0;
    slot_index_o = slot_q;
    slot_job_id_o = srd;
    total_profit_o = sum_q;
    jobs_dropped_o = ovf_q;
    last_slot_o = (slot_q == maxd_q);
    unique case (state_q)
      djs_pkg::ST_LOAD: begin
        if (start_i) begin
          last_d = last_job_i;
          pos_d = cnt_q;
          if (cnt_q < 7'(djs_pkg::MaxJobs)) begin
            new_d.profit = job_profit_i;
            new_d.deadline = dsat;
            new_d.id = cnt_q + 7'd1;
            cnt_d = cnt_q + 7'd1;
            if (dsat > maxd_q) maxd_d = dsat;
            if (cnt_q == '0) begin
              jwe = 1'b1; jwa = '0;
              jwd.profit = job_profit_i; jwd.deadline = dsat;
              jwd.id = 7'd1;
              if (last_job_i) begin
                pos_d = '0; state_d = djs_pkg::ST_RDJOB;
              end
            end else begin
              jra = 6'(cnt_q - 7'd1);
              rdv_d = 1'b1;
              state_d = djs_pkg::ST_SHIFT;
            end
          end else begin
            ovf_d = 1'b1;
            if (last_job_i) begin
              pos_d = '0; state_d = djs_pkg::ST_RDJOB;
            end
          end
        end
      end
      djs_pkg::ST_SHIFT: begin
        // jrd holds entry pos-1
        if (rdv_q) begin
          if (jrd.profit < new_q.profit) begin
            jwe = 1'b1; jwd = jrd;
            pos_d = pos_q - 7'd1;
          end else begin
            jwe = 1'b1;
            if (last_q) begin
              pos_d = '0; state_d = djs_pkg::ST_RDJOB;
            end else state_d = djs_pkg::ST_LOAD;
          end
        end else if (pos_q == '0) begin
          jwe = 1'b1;
          if (last_q) begin
            pos_d = '0; state_d = djs_pkg::ST_RDJOB;
          end else state_d = djs_pkg::ST_LOAD;
        end else begin
          jra = 6'(pos_q - 7'd1);
          rdv_d = 1'b1;
        end
      end
      djs_pkg::ST_RDJOB: begin
        if (rdv_q) begin
          cur_d = jrd;
          slot_d = jrd.deadline;
          sra = 5'(jrd.deadline - 6'd1);
          pos_d = pos_q + 7'd1;
          if (jrd.deadline != '0) state_d = djs_pkg::ST_SCAN;
        end else if (pos_q == cnt_q) begin
          slot_d = 6'd1;
          sra = '0;
          state_d = (maxd_q == '0) ? djs_pkg::ST_CLEAR : djs_pkg::ST_EMIT;
          if (maxd_q == '0) slot_d = '0;
        end else begin
          jra = pos_q[djs_pkg::JobW-1:0];
          rdv_d = 1'b1;
        end
      end
      djs_pkg::ST_SCAN: begin
        // srd holds slot_table[slot-1]
        swa = 5'(slot_q - 6'd1);
        if (srd == '0) begin
          swe = 1'b1; swd = cur_q.id;
          sum_d = sum_add[djs_pkg::SumW] ? djs_pkg::SumLimit
                                         : sum_add[djs_pkg::SumW-1:0];
          state_d = djs_pkg::ST_RDJOB;
        end else if (slot_q == 6'd1) begin
          state_d = djs_pkg::ST_RDJOB;
        end else begin
          slot_d = slot_q - 6'd1;
          sra = 5'(slot_q - 6'd2);
        end
      end
      djs_pkg::ST_EMIT: begin
        valid_o = 1'b1;
        sra = 5'(slot_q);
        if (slot_q == maxd_q) begin
          slot_d = '0; state_d = djs_pkg::ST_CLEAR;
        end else slot_d = slot_q + 6'd1;
      end
      djs_pkg::ST_CLEAR: begin
        swe = 1'b1; swa = slot_q[djs_pkg::SlotAw-1:0]; swd = '0;
        cnt_d = '0; maxd_d = '0; sum_d = '0; ovf_d = 1'b0;
        if (slot_q == 6'(djs_pkg::MaxSlots - 1)) begin
          slot_d = '0; state_d = djs_pkg::ST_LOAD;
        end else slot_d = slot_q + 6'd1;
      end
      default: state_d = djs_pkg::ST_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/djs_job_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module djs_job_mem (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [djs_pkg::JobW-1:0] waddr_i,
  input  wire djs_pkg::job_t         wdata_i,
  input  wire logic [djs_pkg::JobW-1:0] raddr_i,
  output djs_pkg::job_t              rdata_o
);
  djs_pkg::job_t mem_q [djs_pkg::MaxJobs];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/djs_slot_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module djs_slot_mem (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [djs_pkg::SlotAw-1:0] waddr_i,
  input  wire logic [djs_pkg::IdW-1:0]  wdata_i,
  input  wire logic [djs_pkg::SlotAw-1:0] raddr_i,
  output logic [djs_pkg::IdW-1:0]       rdata_o
);
  logic [djs_pkg::IdW-1:0] mem_q [djs_pkg::MaxSlots];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
